@@ src/assert_macros.svh @@
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OTR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/otr_pkg.sv @@
`default_nettype none

package otr_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int STAMP_W    = 64;
  localparam int ADDR_W     = 32;
  localparam int TYPE_W     = 8;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_START     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_STOP      = 2'd2;

  localparam logic [LEN_W-1:0]  ENTRIES_RST    = 6'd32;
  localparam logic [CODE_W-1:0] LOST_START_RST = 8'd0;
  localparam logic [CODE_W-1:0] LOST_STOP_RST  = 8'd1;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] stamp;
    logic [ADDR_W-1:0]  event_addr;
    logic [TYPE_W-1:0]  event_type;
  } in_item_t;

  typedef struct packed {
    op_e                op;
    logic [STAMP_W-1:0] stamp;
    logic [ADDR_W-1:0]  event_addr;
    logic [TYPE_W-1:0]  event_type;
  } cmd_t;

  typedef struct packed {
    logic [STAMP_W-1:0] out_stamp;
    logic [ADDR_W-1:0]  out_addr;
    logic [TYPE_W-1:0]  out_type;
    logic               last_of_drain;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/otr_stream_if.sv @@
`default_nettype none

interface otr_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

@@ src/otr_front.sv @@
`default_nettype none

`include "assert_macros.svh"

module otr_front (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  otr_stream_if.sink    req_i,
  otr_stream_if.source  cmd_o
);

  localparam int PTR_W = (otr_pkg::QUEUE_DEPTH > 1) ? $clog2(otr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(otr_pkg::QUEUE_DEPTH + 1);

  otr_pkg::cmd_t q_mem [otr_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic          push;
  logic          pop;
  otr_pkg::cmd_t in_cmd;

  assign req_i.ready   = (cnt_q != CNT_W'(otr_pkg::QUEUE_DEPTH));
  assign cmd_o.valid   = (cnt_q != '0);
  assign cmd_o.payload = q_mem[rd_ptr_q];

  assign push = req_i.valid && req_i.ready;
  assign pop  = cmd_o.valid && cmd_o.ready;

  // classify the request before it is queued
  always_comb begin
    in_cmd.stamp      = req_i.payload.stamp;
    in_cmd.event_addr = req_i.payload.event_addr;
    in_cmd.event_type = req_i.payload.event_type;
    if (req_i.payload.kind) begin
      in_cmd.op = otr_pkg::OP_DRAIN;
    end else begin
      in_cmd.op = otr_pkg::OP_RECORD;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(otr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(otr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    cnt_d = cnt_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `OTR_ASSERT_IMPL(a_queue_ptrs, (cnt_q == '0) || (cnt_q == CNT_W'(otr_pkg::QUEUE_DEPTH)), wr_ptr_q == rd_ptr_q, "queue pointers disagree with fill count")

endmodule

`default_nettype wire

@@ src/otr_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module otr_back #(
  parameter int RING_DEPTH = otr_pkg::RING_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [otr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [otr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  otr_stream_if.sink                          cmd_i,
  otr_stream_if.source                        res_o
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int LW    = otr_pkg::LEN_W + 1;

  localparam logic [1:0] S_IDLE       = 2'd0;
  localparam logic [1:0] S_LOSS_START = 2'd1;
  localparam logic [1:0] S_LOSS_STOP  = 2'd2;
  localparam logic [1:0] S_EMIT       = 2'd3;

  typedef struct packed {
    logic [otr_pkg::STAMP_W-1:0] stamp;
    logic [otr_pkg::ADDR_W-1:0]  addr;
    logic [otr_pkg::TYPE_W-1:0]  etype;
  } entry_t;

  entry_t ring_mem [RING_DEPTH];

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic [IDX_W-1:0] drn_idx_q, drn_idx_d;

  logic                         lost_valid_q, lost_valid_d;
  logic [otr_pkg::STAMP_W-1:0]  first_lost_q, first_lost_d;
  logic [otr_pkg::STAMP_W-1:0]  last_lost_q, last_lost_d;

  logic [otr_pkg::LEN_W-1:0]    len_q, len_d;
  logic [otr_pkg::CODE_W-1:0]   start_code_q, start_code_d;
  logic [otr_pkg::CODE_W-1:0]   stop_code_q, stop_code_d;

  logic                         out_valid_q, out_valid_d;
  otr_pkg::out_item_t           out_q, out_d;

  logic [otr_pkg::STAMP_W-1:0]  old_stamp_q;
  entry_t                       drn_ent_q;

  logic [LW-1:0]    len_ext;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] drn_nxt;
  logic             cmd_pop;
  logic             out_free;
  logic             load_out;
  logic             wr_en;
  logic             note_loss;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] lim);
    return (idx < lim) ? idx + IDX_W'(1) : '0;
  endfunction

  // ring length saturated to at least two and at most the built depth
  always_comb begin
    len_ext = {1'b0, len_q};
    if (len_ext < LW'(2)) begin
      last_idx = IDX_W'(1);
    end else if (len_ext > LW'(RING_DEPTH)) begin
      last_idx = IDX_W'(RING_DEPTH - 1);
    end else begin
      last_idx = IDX_W'(len_ext - LW'(1));
    end
  end

  assign cmd_i.ready   = (state_q == S_IDLE);
  assign cmd_pop       = cmd_i.valid && cmd_i.ready;
  assign out_free      = !out_valid_q || res_o.ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;
  assign drn_nxt       = wrap_inc(drn_idx_q, last_idx);

  always_comb begin
    state_d      = state_q;
    wr_idx_d     = wr_idx_q;
    old_idx_d    = old_idx_q;
    drn_idx_d    = drn_idx_q;
    lost_valid_d = lost_valid_q;
    first_lost_d = first_lost_q;
    last_lost_d  = last_lost_q;
    len_d        = len_q;
    start_code_d = start_code_q;
    stop_code_d  = stop_code_q;
    out_d        = out_q;
    load_out     = 1'b0;
    wr_en        = 1'b0;
    note_loss    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd_i.payload.op)
            otr_pkg::OP_RECORD: begin
              wr_en = 1'b1;
              if (wr_idx_q == '0 && old_idx_q == '0) begin
                wr_idx_d = IDX_W'(1);
              end else if (wr_idx_q > old_idx_q) begin
                if (wr_idx_q < last_idx) begin
                  wr_idx_d = wr_idx_q + IDX_W'(1);
                end else begin
                  // wrap: the oldest slot is overwritten
                  wr_idx_d = '0;
                  if (drn_idx_q == old_idx_q) begin
                    note_loss = 1'b1;
                    drn_idx_d = IDX_W'(1);
                  end
                  old_idx_d = IDX_W'(1);
                end
              end else if (wr_idx_q < old_idx_q) begin
                if (drn_idx_q == old_idx_q) begin
                  note_loss = 1'b1;
                  drn_idx_d = wrap_inc(old_idx_q, last_idx);
                end
                old_idx_d = wrap_inc(old_idx_q, last_idx);
                wr_idx_d  = wr_idx_q + IDX_W'(1);
              end
            end
            otr_pkg::OP_DRAIN: begin
              if (lost_valid_q) begin
                state_d = S_LOSS_START;
              end else if (drn_idx_q != wr_idx_q) begin
                state_d = S_EMIT;
              end
            end
          endcase
        end
      end
      S_LOSS_START: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_d.out_stamp     = first_lost_q;
          out_d.out_addr      = '0;
          out_d.out_type      = start_code_q;
          out_d.last_of_drain = 1'b0;
          state_d             = S_LOSS_STOP;
        end
      end
      S_LOSS_STOP: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_d.out_stamp     = last_lost_q;
          out_d.out_addr      = '0;
          out_d.out_type      = stop_code_q;
          out_d.last_of_drain = (drn_idx_q == wr_idx_q);
          lost_valid_d        = 1'b0;
          first_lost_d        = '0;
          last_lost_d         = '0;
          state_d             = (drn_idx_q != wr_idx_q) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out            = 1'b1;
          out_d.out_stamp     = drn_ent_q.stamp;
          out_d.out_addr      = drn_ent_q.addr;
          out_d.out_type      = drn_ent_q.etype;
          out_d.last_of_drain = (drn_nxt == wr_idx_q);
          drn_idx_d           = drn_nxt;
          if (drn_nxt == wr_idx_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // the overwritten entry is the one at the oldest slot
    if (note_loss) begin
      if (!lost_valid_q) begin
        first_lost_d = old_stamp_q;
      end
      lost_valid_d = 1'b1;
      last_lost_d  = old_stamp_q;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otr_pkg::REG_ENTRIES_IN_USE: begin
          len_d        = cfg_data_i[otr_pkg::LEN_W-1:0];
          wr_idx_d     = '0;
          old_idx_d    = '0;
          drn_idx_d    = '0;
          lost_valid_d = 1'b0;
          first_lost_d = '0;
          last_lost_d  = '0;
        end
        otr_pkg::REG_LOST_START: begin
          start_code_d = cfg_data_i[otr_pkg::CODE_W-1:0];
        end
        otr_pkg::REG_LOST_STOP: begin
          stop_code_d = cfg_data_i[otr_pkg::CODE_W-1:0];
        end
        default: begin
        end
      endcase
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // ring storage: one write port, two registered read ports with write forwarding
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_idx_q] <= '{stamp: cmd_i.payload.stamp,
                              addr:  cmd_i.payload.event_addr,
                              etype: cmd_i.payload.event_type};
    end
    if (wr_en && (wr_idx_q == old_idx_d)) begin
      old_stamp_q <= cmd_i.payload.stamp;
    end else begin
      old_stamp_q <= ring_mem[old_idx_d].stamp;
    end
    if (wr_en && (wr_idx_q == drn_idx_d)) begin
      drn_ent_q <= '{stamp: cmd_i.payload.stamp,
                     addr:  cmd_i.payload.event_addr,
                     etype: cmd_i.payload.event_type};
    end else begin
      drn_ent_q <= ring_mem[drn_idx_d];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wr_idx_q     <= '0;
      old_idx_q    <= '0;
      drn_idx_q    <= '0;
      lost_valid_q <= 1'b0;
      first_lost_q <= '0;
      last_lost_q  <= '0;
      len_q        <= otr_pkg::ENTRIES_RST;
      start_code_q <= otr_pkg::LOST_START_RST;
      stop_code_q  <= otr_pkg::LOST_STOP_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      wr_idx_q     <= wr_idx_d;
      old_idx_q    <= old_idx_d;
      drn_idx_q    <= drn_idx_d;
      lost_valid_q <= lost_valid_d;
      first_lost_q <= first_lost_d;
      last_lost_q  <= last_lost_d;
      len_q        <= len_d;
      start_code_q <= start_code_d;
      stop_code_q  <= stop_code_d;
      out_valid_q  <= out_valid_d;
    end
  end

  `OTR_ASSERT_IMPL(a_idx_in_ring, 1'b1, (wr_idx_q <= last_idx) && (old_idx_q <= last_idx) && (drn_idx_q <= last_idx), "ring index beyond ring length")
  `OTR_ASSERT_NEXT(a_start_marker, (state_q == S_LOSS_START) && out_free, res_o.valid && (res_o.payload.out_type == $past(start_code_q)) && !res_o.payload.last_of_drain, "loss start marker not presented")
  `OTR_ASSERT_NEXT(a_last_ends_drain, (state_q == S_EMIT) && out_free, (state_q == S_IDLE) == res_o.payload.last_of_drain, "last flag out of step with end of drain")

endmodule

`default_nettype wire

@@ src/overwriting_trace_ring_with_loss_window.sv @@
`default_nettype none

// records: one request per cycle while the queue has room; written to the ring when popped
// drains: queued, then the engine state and output register give the first result, then one
//   result per cycle while the sink is ready; busy while it emits the loss pair and entries
// a two-entry request queue lets new requests in while a drain is being emitted
// reset: indices, loss window and registers return to defaults; ring contents are not cleared
module overwriting_trace_ring_with_loss_window #(
  parameter int RING_DEPTH = otr_pkg::RING_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [otr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [otr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  otr_stream_if.sink                          req_i,
  otr_stream_if.source                        res_o
);

  otr_stream_if #(.payload_t(otr_pkg::cmd_t)) cmd_ch ();

  otr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_o  (cmd_ch)
  );

  otr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_ch),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

@@ tb/overwriting_trace_ring_with_loss_window_tb.sv @@
`timescale 1ns / 1ps

module overwriting_trace_ring_with_loss_window_tb;
  import otr_pkg::*;

  localparam int RING_DEPTH    = RING_DEPTH_DEF;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 28;

  // no register sits at this index
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    in_item_t              item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  fixed;
    logic                  fixed_one;
    out_item_t             fixed_res;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  otr_stream_if #(.payload_t(in_item_t))  req_ch ();
  otr_stream_if #(.payload_t(out_item_t)) res_ch ();

  overwriting_trace_ring_with_loss_window i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  always #1 clk_i = ~clk_i;

  // predicted ring state
  logic [STAMP_W-1:0] ring_stamp [RING_DEPTH];
  logic [ADDR_W-1:0]  ring_addr  [RING_DEPTH];
  logic [TYPE_W-1:0]  ring_type  [RING_DEPTH];
  logic [4:0]         wr_ptr, old_ptr, rd_ptr;
  logic [STAMP_W-1:0] loss_first, loss_last;
  logic               loss_pending;
  logic [LEN_W-1:0]   len_reg;
  logic [CODE_W-1:0]  start_code, stop_code;

  out_item_t drain_out [$];
  out_item_t due_results [$];
  out_item_t want_res;
  plan_row_t stim_plan [$];

  // typed-in expectation travelling with the request on offer
  logic      table_check;
  logic      table_one;
  out_item_t table_res;

  int  errors = 0;
  int  quiet_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_armed = 1'b0;

  function automatic logic [LEN_W-1:0] ring_len(input logic [LEN_W-1:0] n);
    if (n < 2) return 2;
    if (n > RING_DEPTH) return LEN_W'(RING_DEPTH);
    return n;
  endfunction

  function automatic void ring_restart();
    wr_ptr       = '0;
    old_ptr      = '0;
    rd_ptr       = '0;
    loss_first   = '0;
    loss_last    = '0;
    loss_pending = 1'b0;
  endfunction

  // oldest undrained entry is about to be overwritten
  function automatic void note_loss();
    if (!loss_pending) begin
      loss_first   = ring_stamp[rd_ptr];
      loss_pending = 1'b1;
    end
    loss_last = ring_stamp[rd_ptr];
  endfunction

  function automatic void ring_predict(input in_item_t it);
    logic [4:0] c, h, d, last;
    int         guard;
    out_item_t  r;
    last = 5'(ring_len(len_reg) - 1);
    drain_out.delete();
    if (it.kind == OP_RECORD) begin
      c = wr_ptr;
      h = old_ptr;
      ring_stamp[c] = it.stamp;
      ring_addr[c]  = it.event_addr;
      ring_type[c]  = it.event_type;
      if (c == 0 && h == 0) begin
        wr_ptr = 5'd1;
      end else if (c > h) begin
        if (c < last) begin
          wr_ptr = 5'(c + 1);
        end else begin
          wr_ptr = '0;
          if (rd_ptr == h) begin
            note_loss();
            rd_ptr = 5'd1;
          end
          old_ptr = 5'd1;
        end
      end else if (c < h) begin
        if (rd_ptr == h) begin
          note_loss();
          rd_ptr = (h < last) ? 5'(h + 1) : '0;
        end
        old_ptr = (h < last) ? 5'(h + 1) : '0;
        wr_ptr  = 5'(c + 1);
      end
    end else begin
      if (loss_pending) begin
        drain_out.push_back({loss_first, {ADDR_W{1'b0}}, start_code, 1'b0});
        drain_out.push_back({loss_last, {ADDR_W{1'b0}}, stop_code, 1'b0});
        loss_first   = '0;
        loss_last    = '0;
        loss_pending = 1'b0;
      end
      d     = rd_ptr;
      guard = 0;
      while (d != wr_ptr && guard <= last) begin
        drain_out.push_back({ring_stamp[d], ring_addr[d], ring_type[d], 1'b0});
        d = (d < last) ? 5'(d + 1) : '0;
        guard++;
      end
      rd_ptr = d;
      if (drain_out.size() > 0) begin
        r = drain_out.pop_back();
        r.last_of_drain = 1'b1;
        drain_out.push_back(r);
      end
    end
  endfunction

  function automatic int field_bad(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      len_reg    = ENTRIES_RST;
      start_code = LOST_START_RST;
      stop_code  = LOST_STOP_RST;
      ring_restart();
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENTRIES_IN_USE: begin
            len_reg = cfg_data_i[LEN_W-1:0];
            ring_restart();
          end
          REG_LOST_START: start_code = cfg_data_i;
          REG_LOST_STOP:  stop_code  = cfg_data_i;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        ring_predict(req_ch.payload);
        if (!table_check) begin
          foreach (drain_out[k]) due_results.push_back(drain_out[k]);
        end else if (table_one) begin
          due_results.push_back(table_res);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, res_ch.payload);
          errors++;
        end else begin
          want_res = due_results.pop_front();
          errors += field_bad("out_stamp", want_res.out_stamp, res_ch.payload.out_stamp);
          errors += field_bad("out_addr", want_res.out_addr, res_ch.payload.out_addr);
          errors += field_bad("out_type", want_res.out_type, res_ch.payload.out_type);
          errors += field_bad("last_of_drain", want_res.last_of_drain,
                              res_ch.payload.last_of_drain);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the ring up
  initial begin : rx_side
    int held;
    held = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && held < HOLD_CYCLES) begin
        res_ch.ready <= 1'b0;
        held++;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic in_item_t random_item(input op_e op);
    in_item_t it;
    it.kind = op;
    case ($urandom_range(0, 9))
      0:       it.stamp = '0;
      1:       it.stamp = '1;
      default: it.stamp = {$urandom, $urandom};
    endcase
    it.event_addr = $urandom;
    it.event_type = TYPE_W'($urandom);
    return it;
  endfunction

  function automatic void plan_record(input logic [STAMP_W-1:0] s, input logic [ADDR_W-1:0] a,
                                      input logic [TYPE_W-1:0] t);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = {OP_RECORD, s, a, t};
    stim_plan.push_back(row);
  endfunction

  function automatic void plan_drain(input logic fixed, input logic one, input out_item_t r);
    plan_row_t row;
    row           = '0;
    row.kind      = ROW_ITEM;
    row.item      = random_item(OP_DRAIN);
    row.fixed     = fixed;
    row.fixed_one = one;
    row.fixed_res = r;
    stim_plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_plan.push_back(row);
  endfunction

  task automatic send_item(input in_item_t it, input logic fixed, input logic one,
                           input out_item_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    table_check    <= fixed;
    table_one      <= one;
    table_res      <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // called at a falling edge; returns once the ring has gone quiet
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input idle_mode_e mode, input logic [7:0] len_val,
                           input logic [7:0] start_val, input logic [7:0] stop_val,
                           input bit squeeze);
    int sent;
    int burst;
    int span;
    wait_idle();
    write_reg(REG_ENTRIES_IN_USE, len_val);
    write_reg(REG_LOST_START, start_val);
    write_reg(REG_LOST_STOP, stop_val);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      IDLE_BOTH: begin send_idle_pct = 22; recv_stall_pct = 22; end
      default: ;
    endcase
    if (squeeze) hold_armed = 1'b1;
    span = int'(ring_len(len_val[LEN_W-1:0]));
    sent = 0;
    // bursts of records, long enough at times to wrap and lose entries, then a drain or two
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(0, span + 2);
      repeat (burst) begin
        send_item(random_item(OP_RECORD), 1'b0, 1'b0, '0);
        sent++;
      end
      send_item(random_item(OP_DRAIN), 1'b0, 1'b0, '0);
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        send_item(random_item(OP_DRAIN), 1'b0, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    table_check    = 1'b0;
    table_one      = 1'b0;
    table_res      = '0;

    // empty ring after reset, then single entries at the field extremes
    plan_drain(1'b1, 1'b0, '0);
    plan_record('1, '1, '1);
    plan_drain(1'b1, 1'b1, {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1});
    plan_record('0, '0, '0);
    plan_drain(1'b1, 1'b1, {64'h0, 32'h0, 8'h00, 1'b1});
    plan_drain(1'b1, 1'b0, '0);
    // shortest ring: a lost entry whose stamp is zero still gives a marker pair
    plan_reg(REG_ENTRIES_IN_USE, 8'd2);
    plan_record(64'h0, 32'h0000_0010, 8'h11);
    plan_record(64'h1, 32'h0000_0020, 8'h22);
    plan_drain(1'b0, 1'b0, '0);
    // loss window spanning several overwritten entries, marker codes at extremes
    plan_reg(REG_LOST_START, 8'hFF);
    plan_reg(REG_LOST_STOP, 8'h00);
    plan_record(64'h10, 32'hA000_0001, 8'h31);
    plan_record(64'h11, 32'hA000_0002, 8'h32);
    plan_record(64'h12, 32'hA000_0003, 8'h33);
    plan_record(64'h13, 32'hA000_0004, 8'h34);
    plan_drain(1'b0, 1'b0, '0);
    plan_reg(REG_UNUSED, 8'h5A);
    plan_reg(REG_LOST_STOP, 8'hFF);
    // length below the range saturates to two
    plan_reg(REG_ENTRIES_IN_USE, 8'd0);
    plan_record(64'h7FFF_FFFF_FFFF_FFFF, 32'h1234_5678, 8'h7F);
    plan_record(64'h20, 32'h8765_4321, 8'h01);
    plan_record(64'h21, 32'h0F0F_0F0F, 8'hFE);
    plan_drain(1'b0, 1'b0, '0);
    // length above the range saturates to the full depth
    plan_reg(REG_ENTRIES_IN_USE, 8'd63);
    plan_record(64'h8000_0000_0000_0000, 32'h8000_0001, 8'h80);
    plan_drain(1'b1, 1'b1, {64'h8000_0000_0000_0000, 32'h8000_0001, 8'h80, 1'b1});

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_plan[i]) begin
      if (stim_plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(stim_plan[i].reg_idx, stim_plan[i].reg_val);
      end else begin
        send_item(stim_plan[i].item, stim_plan[i].fixed, stim_plan[i].fixed_one,
                  stim_plan[i].fixed_res);
      end
    end

    run_phase(IDLE_NONE, 8'd2, 8'hFF, 8'h00, 1'b0);
    run_phase(IDLE_SEND, 8'd32, 8'($urandom), 8'($urandom), 1'b0);
    run_phase(IDLE_RECV, 8'($urandom_range(3, 8)), 8'($urandom), 8'($urandom), 1'b0);
    run_phase(IDLE_BOTH, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    run_phase(IDLE_NONE, 8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom), 1'b1);
    run_phase(IDLE_BOTH, 8'd1, 8'h00, 8'hFF, 1'b0);

    wait_idle();
    if (errors == 0 && due_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ overwriting_trace_ring_with_loss_window.f @@
+incdir+src
src/otr_pkg.sv
src/otr_stream_if.sv
src/otr_front.sv
src/otr_back.sv
src/overwriting_trace_ring_with_loss_window.sv
tb/overwriting_trace_ring_with_loss_window_tb.sv
